// File: rtl/core/climate_sensor_alarm_monitor_top_macros.svh
// Assertion macros used by the climate alarm monitor core (csam_core).
`ifndef CLIMATE_SENSOR_ALARM_MONITOR_TOP_MACROS_SVH
`define CLIMATE_SENSOR_ALARM_MONITOR_TOP_MACROS_SVH

// Clocked check, held off while reset is high.
`define CSAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define CSAM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/csam_pkg.sv
// Package: widths, register codes, reset values and the configuration struct.
`default_nettype none

package csam_pkg;

  localparam int TEMP_W       = 8;
  localparam int HUMID_W      = 8;
  localparam int PERIOD_W     = 4;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 8;
  localparam int TICK_W       = 4;
  localparam int CRIT_CNT_W   = 2;
  localparam int CALM_CNT_W   = 8;

  localparam int CALM_SAMPLES_DEF     = 5;
  localparam int CRITICAL_SAMPLES_DEF = 3;

  localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST  = 4'd2;
  localparam logic [TEMP_W-1:0]   CRITICAL_TEMP_RST  = 8'd35;
  localparam logic [HUMID_W-1:0]  CRITICAL_HUMID_RST = 8'd80;
  localparam logic [TEMP_W-1:0]   ABNORMAL_TEMP_RST  = 8'd30;
  localparam logic [HUMID_W-1:0]  ABNORMAL_HUMID_RST = 8'd49;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MONITOR_ENABLE = 3'd0,
    REG_SAMPLE_PERIOD  = 3'd1,
    REG_ALERT_MODE     = 3'd2,
    REG_CRITICAL_TEMP  = 3'd3,
    REG_CRITICAL_HUMID = 3'd4,
    REG_ABNORMAL_TEMP  = 3'd5,
    REG_ABNORMAL_HUMID = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic                monitor_enable;
    logic [PERIOD_W-1:0] sample_period;
    logic                alert_mode;
    logic [TEMP_W-1:0]   critical_temp;
    logic [HUMID_W-1:0]  critical_humid;
    logic [TEMP_W-1:0]   abnormal_temp;
    logic [HUMID_W-1:0]  abnormal_humid;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/core/csam_ifs.sv
// Channel interfaces: sensor tick requests in, alarm results out.
`default_nettype none

interface csam_sample_if
  import csam_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [TEMP_W-1:0]  temp_reading;
  logic [HUMID_W-1:0] humid_reading;
  logic               read_ok;

  modport source (output valid, output temp_reading, output humid_reading,
                  output read_ok, input ready);
  modport sink   (input valid, input temp_reading, input humid_reading,
                  input read_ok, output ready);
endinterface

interface csam_result_if;
  logic valid;
  logic ready;
  logic led_on;
  logic sample_taken;
  logic read_failed;
  logic alert_started;
  logic alert_cleared;
  logic reset_request;

  modport source (output valid, output led_on, output sample_taken,
                  output read_failed, output alert_started, output alert_cleared,
                  output reset_request, input ready);
  modport sink   (input valid, input led_on, input sample_taken,
                  input read_failed, input alert_started, input alert_cleared,
                  input reset_request, output ready);
endinterface

`default_nettype wire

// File: rtl/core/csam_cfg_regs.sv
// Configuration register bank with a plain write port.
`default_nettype none

module csam_cfg_regs
  import csam_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.monitor_enable <= 1'b0;
      cfg.sample_period  <= SAMPLE_PERIOD_RST;
      cfg.alert_mode     <= 1'b0;
      cfg.critical_temp  <= CRITICAL_TEMP_RST;
      cfg.critical_humid <= CRITICAL_HUMID_RST;
      cfg.abnormal_temp  <= ABNORMAL_TEMP_RST;
      cfg.abnormal_humid <= ABNORMAL_HUMID_RST;
    end else if (cfg_we) begin
      // drop writes to unmapped indexes
      case (cfg_index_t'(cfg_index))
        REG_MONITOR_ENABLE: cfg.monitor_enable <= cfg_data[0];
        REG_SAMPLE_PERIOD:  cfg.sample_period  <= cfg_data[PERIOD_W-1:0];
        REG_ALERT_MODE:     cfg.alert_mode     <= cfg_data[0];
        REG_CRITICAL_TEMP:  cfg.critical_temp  <= cfg_data[TEMP_W-1:0];
        REG_CRITICAL_HUMID: cfg.critical_humid <= cfg_data[HUMID_W-1:0];
        REG_ABNORMAL_TEMP:  cfg.abnormal_temp  <= cfg_data[TEMP_W-1:0];
        REG_ABNORMAL_HUMID: cfg.abnormal_humid <= cfg_data[HUMID_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/csam_core.sv
// Per-tick alarm logic: monitor state, next-state logic and result register.
`default_nettype none

module csam_core
  import csam_pkg::*;
#(
  parameter int CALM_SAMPLES     = CALM_SAMPLES_DEF,
  parameter int CRITICAL_SAMPLES = CRITICAL_SAMPLES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire cfg_t         cfg,
  csam_sample_if.sink       sample_in,
  csam_result_if.source     result_out
);

  `include "climate_sensor_alarm_monitor_top_macros.svh"

  localparam logic [CRIT_CNT_W-1:0] CRIT_LIMIT = CRIT_CNT_W'(CRITICAL_SAMPLES);
  localparam logic [CALM_CNT_W-1:0] CALM_LIMIT = CALM_CNT_W'(CALM_SAMPLES);

  logic [TICK_W-1:0]     tick_count,     tick_count_next;
  logic [CRIT_CNT_W-1:0] critical_count, critical_count_next;
  logic [CALM_CNT_W-1:0] calm_count,     calm_count_next;
  logic                  flash_active,   flash_active_next;
  logic                  blink_phase,    blink_phase_next;
  logic                  led_level,      led_level_next;

  logic taken, failed, started, cleared, crit_clear;
  logic is_critical, is_abnormal;
  logic accept;

  assign sample_in.ready = !result_out.valid || result_out.ready;
  assign accept          = sample_in.valid && sample_in.ready;

  assign is_critical = (sample_in.temp_reading >= cfg.critical_temp) ||
                       (sample_in.humid_reading >= cfg.critical_humid);
  assign is_abnormal = (sample_in.temp_reading >= cfg.abnormal_temp) ||
                       (sample_in.humid_reading >= cfg.abnormal_humid);

  always_comb begin
    tick_count_next     = tick_count;
    critical_count_next = critical_count;
    calm_count_next     = calm_count;
    flash_active_next   = flash_active;
    blink_phase_next    = blink_phase;
    led_level_next      = led_level;
    taken      = 1'b0;
    failed     = 1'b0;
    started    = 1'b0;
    cleared    = 1'b0;
    crit_clear = 1'b0;

    if (cfg.monitor_enable) begin
      if (tick_count >= cfg.sample_period) begin
        tick_count_next = '0;
        if (sample_in.read_ok) begin
          taken = 1'b1;
          if (is_critical) begin
            critical_count_next = critical_count + CRIT_CNT_W'(1);
            crit_clear          = (critical_count_next == CRIT_LIMIT);
          end
          if (!cfg.alert_mode) begin
            flash_active_next = 1'b0;
            led_level_next    = 1'b0;
          end else if (is_abnormal) begin
            if (!flash_active) begin
              started           = 1'b1;
              flash_active_next = 1'b1;
              calm_count_next   = '0;
            end
          end else begin
            calm_count_next = calm_count + CALM_CNT_W'(1);
            if ((calm_count_next == CALM_LIMIT) && flash_active) begin
              calm_count_next   = '0;
              flash_active_next = 1'b0;
              led_level_next    = 1'b0;
              cleared           = 1'b1;
            end
          end
        end else begin
          failed = 1'b1;
        end
      end
      tick_count_next = tick_count_next + TICK_W'(1);
    end

    if (flash_active_next) begin
      blink_phase_next = ~blink_phase;
      led_level_next   = blink_phase_next;
    end

    // third critical sample: wipe all state, drop alert start and clear
    if (crit_clear) begin
      tick_count_next     = '0;
      critical_count_next = '0;
      calm_count_next     = '0;
      flash_active_next   = 1'b0;
      blink_phase_next    = 1'b0;
      led_level_next      = 1'b0;
      started             = 1'b0;
      cleared             = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count       <= '0;
      critical_count   <= '0;
      calm_count       <= '0;
      flash_active     <= 1'b0;
      blink_phase      <= 1'b0;
      led_level        <= 1'b0;
      result_out.valid <= 1'b0;
    end else begin
      if (accept) begin
        tick_count       <= tick_count_next;
        critical_count   <= critical_count_next;
        calm_count       <= calm_count_next;
        flash_active     <= flash_active_next;
        blink_phase      <= blink_phase_next;
        led_level        <= led_level_next;
        result_out.valid <= 1'b1;
      end else if (result_out.ready) begin
        result_out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_out.led_on        <= led_level_next;
      result_out.sample_taken  <= taken;
      result_out.read_failed   <= failed;
      result_out.alert_started <= started;
      result_out.alert_cleared <= cleared;
      result_out.reset_request <= crit_clear;
    end
  end

  `CSAM_ASSERT(a_reset_clears_state,
    (accept && crit_clear) |=> (tick_count == '0 && critical_count == '0 && !flash_active),
    "critical reset did not clear the monitor state")
  `CSAM_ASSERT(a_reset_req_led_off,
    (result_out.valid && result_out.reset_request) |-> !result_out.led_on,
    "reset request delivered with LED on")
  `CSAM_ASSERT(a_start_clear_exclusive,
    (accept && started) |-> (!cleared && taken && !failed),
    "alert start without a valid sample or together with a clear")
  `CSAM_ASSERT(a_idle_state_holds,
    !accept |=> ($stable(tick_count) && $stable(critical_count) && $stable(flash_active)),
    "monitor state changed without an accepted tick")

endmodule

`default_nettype wire

// File: rtl/core/climate_sensor_alarm_monitor_top.sv
// Top level of the climate alarm monitor: register bank and per-tick core.
//
//   channel     dir  payload                                           handshake
//   sample_in   in   temp_reading, humid_reading, read_ok              valid/ready
//   result_out  out  led_on, sample_taken, read_failed,                valid/ready
//                    alert_started, alert_cleared, reset_request
//   cfg         in   cfg_index, cfg_data                               cfg_we
//
// One tick request is taken per cycle while input ready is high; its result
// appears in the result register on the next cycle.
// Ticks keep flowing while a result is held, as long as the sink takes it.
// A stalled result holds the register and input ready drops until it is taken.
// rst is synchronous: it restores register defaults and clears all monitor state.
`default_nettype none

module climate_sensor_alarm_monitor_top
  import csam_pkg::*;
#(
  parameter int CALM_SAMPLES     = CALM_SAMPLES_DEF,
  parameter int CRITICAL_SAMPLES = CRITICAL_SAMPLES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  csam_sample_if.sink                 sample_in,
  csam_result_if.source               result_out,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg;

  csam_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  csam_core #(
    .CALM_SAMPLES     (CALM_SAMPLES),
    .CRITICAL_SAMPLES (CRITICAL_SAMPLES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .sample_in  (sample_in),
    .result_out (result_out)
  );

endmodule

`default_nettype wire

// File: sim/climate_sensor_alarm_monitor_top_tb.sv
// Self-checking testbench for the climate alarm monitor: tick driver, result monitor, predictor.
module climate_sensor_alarm_monitor_top_tb
  import csam_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_TICKS  = 160;
  localparam int NUM_PHASES   = 8;

  typedef struct packed {
    logic [TEMP_W-1:0]  temp;
    logic [HUMID_W-1:0] humid;
    logic               ok;
  } sensor_tick_t;

  typedef struct packed {
    logic led_on;
    logic sample_taken;
    logic read_failed;
    logic alert_started;
    logic alert_cleared;
    logic reset_request;
  } alarm_flags_t;

  typedef enum int {CAT_CALM, CAT_ABNORMAL, CAT_CRITICAL, CAT_NOISE} reading_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  csam_sample_if sample_ch ();
  csam_result_if result_ch ();

  climate_sensor_alarm_monitor_top u_top (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (sample_ch),
    .result_out (result_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  initial begin
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // Shadow of the block: registers and monitor state
  cfg_t                  shadow_cfg;
  logic [TICK_W-1:0]     tick_cnt;
  logic [CRIT_CNT_W-1:0] crit_cnt;
  logic [CALM_CNT_W-1:0] calm_cnt;
  logic                  flashing;
  logic                  blink;
  logic                  led;

  sensor_tick_t tick_q[$];
  alarm_flags_t alarm_expected_q[$];
  int ticks_queued = 0;
  int alarms_checked = 0;
  int mismatches = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  logic pressure_on = 1'b0;
  logic pressure_done = 1'b0;
  int hold_count = 0;
  int quiet_cycles = 0;
  int n_samples = 0, n_failed = 0, n_started = 0, n_cleared = 0, n_resets = 0;
  int n_configs = 0;

  int unsigned period_plan [NUM_PHASES] = '{2, 1, 10, 0, 15, 3, 2, 5};

  function automatic void clear_monitor_state();
    tick_cnt = '0;
    crit_cnt = '0;
    calm_cnt = '0;
    flashing = 1'b0;
    blink    = 1'b0;
    led      = 1'b0;
  endfunction

  function automatic alarm_flags_t predict_alarm(sensor_tick_t t);
    alarm_flags_t r;
    r = '0;
    if (shadow_cfg.monitor_enable) begin
      if (tick_cnt >= shadow_cfg.sample_period) begin
        tick_cnt = '0;
        if (t.ok) begin
          r.sample_taken = 1'b1;
          if (t.temp >= shadow_cfg.critical_temp || t.humid >= shadow_cfg.critical_humid) begin
            crit_cnt = crit_cnt + CRIT_CNT_W'(1);
            if (crit_cnt == CRITICAL_SAMPLES_DEF) begin
              clear_monitor_state();
              r.reset_request = 1'b1;
              return r;
            end
          end
          if (!shadow_cfg.alert_mode) begin
            flashing = 1'b0;
            led      = 1'b0;
          end else if (t.temp >= shadow_cfg.abnormal_temp ||
                       t.humid >= shadow_cfg.abnormal_humid) begin
            if (!flashing) begin
              r.alert_started = 1'b1;
              flashing = 1'b1;
              calm_cnt = '0;
            end
          end else begin
            calm_cnt = calm_cnt + CALM_CNT_W'(1);
            if (calm_cnt == CALM_SAMPLES_DEF && flashing) begin
              calm_cnt = '0;
              flashing = 1'b0;
              led      = 1'b0;
              r.alert_cleared = 1'b1;
            end
          end
        end else begin
          r.read_failed = 1'b1;
        end
      end
      tick_cnt = tick_cnt + TICK_W'(1);
    end
    if (flashing) begin
      blink = ~blink;
      led   = blink;
    end
    r.led_on = led;
    return r;
  endfunction

  // Tick driver: offer the next pending request, hold it until taken
  always @(posedge clk) begin : drive_ticks
    sensor_tick_t taken;
    sensor_tick_t nxt;
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        taken.temp  = sample_ch.temp_reading;
        taken.humid = sample_ch.humid_reading;
        taken.ok    = sample_ch.read_ok;
        alarm_expected_q.push_back(predict_alarm(taken));
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (tick_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = tick_q.pop_front();
          sample_ch.valid         <= 1'b1;
          sample_ch.temp_reading  <= nxt.temp;
          sample_ch.humid_reading <= nxt.humid;
          sample_ch.read_ok       <= nxt.ok;
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (pressure_on && !pressure_done) begin
      hold_count <= hold_count + 1;
      if (hold_count == HOLD_CYCLES - 1) pressure_done <= 1'b1;
    end
  end

  // Result monitor: compare each taken result with the oldest prediction
  always @(posedge clk) begin : check_alarms
    alarm_flags_t got;
    alarm_flags_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got.led_on        = result_ch.led_on;
        got.sample_taken  = result_ch.sample_taken;
        got.read_failed   = result_ch.read_failed;
        got.alert_started = result_ch.alert_started;
        got.alert_cleared = result_ch.alert_cleared;
        got.reset_request = result_ch.reset_request;
        if (alarm_expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result led=%b taken=%b failed=%b start=%b clear=%b rst=%b",
                   $realtime, got.led_on, got.sample_taken, got.read_failed,
                   got.alert_started, got.alert_cleared, got.reset_request);
        end else begin
          want = alarm_expected_q.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: mismatch exp led=%b taken=%b failed=%b start=%b clear=%b rst=%b",
                     $realtime, want.led_on, want.sample_taken, want.read_failed,
                     want.alert_started, want.alert_cleared, want.reset_request);
            $display("%0t:          got led=%b taken=%b failed=%b start=%b clear=%b rst=%b",
                     $realtime, got.led_on, got.sample_taken, got.read_failed,
                     got.alert_started, got.alert_cleared, got.reset_request);
          end
          n_samples += int'(want.sample_taken);
          n_failed  += int'(want.read_failed);
          n_started += int'(want.alert_started);
          n_cleared += int'(want.alert_cleared);
          n_resets  += int'(want.reset_request);
        end
        alarms_checked++;
      end
      if (pressure_on && !pressure_done) begin
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, giving up", $realtime, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_MONITOR_ENABLE: shadow_cfg.monitor_enable = data[0];
      REG_SAMPLE_PERIOD:  shadow_cfg.sample_period  = data[PERIOD_W-1:0];
      REG_ALERT_MODE:     shadow_cfg.alert_mode     = data[0];
      REG_CRITICAL_TEMP:  shadow_cfg.critical_temp  = data;
      REG_CRITICAL_HUMID: shadow_cfg.critical_humid = data;
      REG_ABNORMAL_TEMP:  shadow_cfg.abnormal_temp  = data;
      REG_ABNORMAL_HUMID: shadow_cfg.abnormal_humid = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_config(cfg_t c);
    write_reg(REG_MONITOR_ENABLE, CFG_DATA_W'(c.monitor_enable));
    write_reg(REG_SAMPLE_PERIOD,  CFG_DATA_W'(c.sample_period));
    write_reg(REG_ALERT_MODE,     CFG_DATA_W'(c.alert_mode));
    write_reg(REG_CRITICAL_TEMP,  c.critical_temp);
    write_reg(REG_CRITICAL_HUMID, c.critical_humid);
    write_reg(REG_ABNORMAL_TEMP,  c.abnormal_temp);
    write_reg(REG_ABNORMAL_HUMID, c.abnormal_humid);
    n_configs++;
  endtask

  task automatic queue_tick(int temp, int humid, bit ok);
    sensor_tick_t t;
    t.temp  = TEMP_W'(temp);
    t.humid = HUMID_W'(humid);
    t.ok    = ok;
    tick_q.push_back(t);
    ticks_queued++;
  endtask

  // Wait until every queued tick has its result checked, then let the pipe drain
  task automatic wait_until_settled();
    while (alarms_checked != ticks_queued) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic int below(int thr);
    return (thr == 0) ? $urandom_range(255) : $urandom_range(thr - 1);
  endfunction

  function automatic int span(int lo, int hi_excl);
    return (lo < hi_excl) ? $urandom_range(hi_excl - 1, lo) : $urandom_range(255);
  endfunction

  // Bias readings around the current thresholds so that flashing starts and stops
  task automatic queue_reading(reading_kind_t kind);
    int temp;
    int humid;
    bit ok;
    ok = ($urandom_range(99) >= 8);
    case (kind)
      CAT_CALM: begin
        temp  = below(shadow_cfg.abnormal_temp);
        humid = below(shadow_cfg.abnormal_humid);
      end
      CAT_ABNORMAL: begin
        if ($urandom_range(1)) begin
          temp  = span(shadow_cfg.abnormal_temp, shadow_cfg.critical_temp);
          humid = below(shadow_cfg.abnormal_humid);
        end else begin
          temp  = below(shadow_cfg.abnormal_temp);
          humid = span(shadow_cfg.abnormal_humid, shadow_cfg.critical_humid);
        end
      end
      CAT_CRITICAL: begin
        temp  = $urandom_range(255, shadow_cfg.critical_temp);
        humid = $urandom_range(255);
      end
      default: begin
        temp  = $urandom_range(255);
        humid = $urandom_range(255);
        ok    = ($urandom_range(1) != 0);
      end
    endcase
    queue_tick(temp, humid, ok);
  endtask

  initial begin : stimulus
    cfg_t c;
    int pick;
    int n_ticks;
    sample_ch.valid         = 1'b0;
    sample_ch.temp_reading  = '0;
    sample_ch.humid_reading = '0;
    sample_ch.read_ok       = 1'b0;
    result_ch.ready         = 1'b0;
    shadow_cfg.monitor_enable = 1'b0;
    shadow_cfg.sample_period  = SAMPLE_PERIOD_RST;
    shadow_cfg.alert_mode     = 1'b0;
    shadow_cfg.critical_temp  = CRITICAL_TEMP_RST;
    shadow_cfg.critical_humid = CRITICAL_HUMID_RST;
    shadow_cfg.abnormal_temp  = ABNORMAL_TEMP_RST;
    shadow_cfg.abnormal_humid = ABNORMAL_HUMID_RST;
    clear_monitor_state();

    while (rst) @(posedge clk);

    // Register defaults: monitoring off, ticks pass untouched
    queue_tick(255, 255, 1'b1);
    queue_tick(0, 0, 1'b0);
    wait_until_settled();

    c = shadow_cfg;
    c.monitor_enable = 1'b1;
    c.sample_period  = '0;
    c.alert_mode     = 1'b1;
    program_config(c);
    queue_tick(20, 20, 1'b0);     // invalid read
    queue_tick(30, 0, 1'b1);      // abnormal temperature at threshold
    queue_tick(29, 48, 1'b1);     // calm just below both thresholds
    repeat (4) queue_tick(0, 0, 1'b1);
    queue_tick(0, 49, 1'b1);      // abnormal humidity
    queue_tick(34, 79, 1'b1);
    queue_tick(35, 0, 1'b1);      // critical temperature
    queue_tick(0, 80, 1'b1);      // critical humidity
    queue_tick(255, 255, 1'b1);   // third critical: reset request
    queue_tick(31, 0, 1'b1);
    wait_until_settled();

    // Disabled: counters hold, blink keeps going
    write_reg(REG_MONITOR_ENABLE, CFG_DATA_W'(0));
    queue_tick(8'hAA, 8'h55, 1'b1);
    queue_tick(8'h55, 8'hAA, 1'b0);
    queue_tick(255, 255, 1'b1);
    wait_until_settled();

    // Normal mode forces the LED off
    write_reg(REG_ALERT_MODE, CFG_DATA_W'(0));
    write_reg(REG_MONITOR_ENABLE, CFG_DATA_W'(1));
    queue_tick(31, 0, 1'b1);
    queue_tick(31, 0, 1'b1);
    wait_until_settled();

    // Write to an unused index: must change nothing
    write_reg(REG_UNUSED, 8'hFF);
    queue_tick(255, 0, 1'b1);
    queue_tick(0, 255, 1'b1);
    wait_until_settled();

    for (int p = 0; p < NUM_PHASES; p++) begin
      c.monitor_enable = (p != 5);
      c.alert_mode     = (p != 3);
      c.sample_period  = PERIOD_W'(period_plan[p]);
      if (p == 2) begin
        c.abnormal_temp  = 8'd0;
        c.abnormal_humid = 8'd0;
        c.critical_temp  = 8'd255;
        c.critical_humid = 8'd255;
      end else if (p == 6) begin
        c.abnormal_temp  = 8'd255;
        c.abnormal_humid = 8'd255;
        c.critical_temp  = 8'd0;
        c.critical_humid = 8'd0;
      end else begin
        c.abnormal_temp  = TEMP_W'($urandom_range(60, 10));
        c.abnormal_humid = HUMID_W'($urandom_range(60, 10));
        c.critical_temp  = c.abnormal_temp + TEMP_W'($urandom_range(60, 5));
        c.critical_humid = c.abnormal_humid + HUMID_W'($urandom_range(60, 5));
      end
      program_config(c);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 87; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 87; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      // Stall the output while the input keeps offering, so the block backs up
      if (p == 4) pressure_on = 1'b1;
      n_ticks = (p == 5) ? 60 : PHASE_TICKS;
      for (int i = 0; i < n_ticks; i++) begin
        pick = $urandom_range(99);
        if (pick < 8) queue_reading(CAT_CRITICAL);
        else if (pick < 35) queue_reading(CAT_ABNORMAL);
        else if (pick < 90) queue_reading(CAT_CALM);
        else queue_reading(CAT_NOISE);
      end
      wait_until_settled();
    end

    if (alarm_expected_q.size() != 0) begin
      mismatches++;
      $display("%0t: %0d predicted results never arrived", $realtime, alarm_expected_q.size());
    end
    $display("Run: %0d ticks over %0d settings, %0d samples, %0d invalid reads,",
             alarms_checked, n_configs, n_samples, n_failed);
    $display("     %0d alert starts, %0d alert clears, %0d reset requests, %0d mismatches.",
             n_started, n_cleared, n_resets, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
